// ===== sv/cef_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cef_pkg - shared types and constants
// Field widths, result status codes, command kinds and the word format that
// passes from the front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package cef_pkg;

  // field widths
  localparam int KEY_W    = 16;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;

  // op codes of an input word
  localparam logic OP_POST = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAKEN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // command queue geometry
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // classified command
  typedef enum logic [1:0] {
    KIND_POST  = 2'd0,
    KIND_MERGE = 2'd1,
    KIND_TAKE  = 2'd2,
    KIND_DROP  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [KEY_W-1:0]    key;
    logic [WORD_W-1:0]   word;
  } cmd_t;

  // command queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cq_status_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_LOOK  = 2'b01,
    BK_APPLY = 2'b10
  } back_state_e;

endpackage
`default_nettype wire

// ===== sv/cef_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cef_front - command intake
// Accepts a word when the command queue has room and classifies it into
// post, merge, take or drop before it enters the queue.
// ----------------------------------------------------------------------------
module cef_front (
  input  wire logic                        start,
  input  wire logic                        op_i,
  input  wire logic [cef_pkg::KEY_W-1:0]   event_key_i,
  input  wire logic [cef_pkg::WORD_W-1:0]  event_word_i,
  input  wire logic                        coalesce_i,
  input  wire cef_pkg::cq_status_t         cq_stat_i,
  output logic                             busy,
  output logic                             push_o,
  output cef_pkg::cmd_t                    cmd_o
);

  // accept only while the queue has room
  assign busy   = cq_stat_i.full;
  assign push_o = start & ~cq_stat_i.full;

  // classify: key zero posts are dropped up front
  always_comb begin
    cmd_o.key  = event_key_i;
    cmd_o.word = event_word_i;
    if (op_i == cef_pkg::OP_TAKE) begin
      cmd_o.kind = cef_pkg::KIND_TAKE;
    end else if (event_key_i == '0) begin
      cmd_o.kind = cef_pkg::KIND_DROP;
    end else if (coalesce_i) begin
      cmd_o.kind = cef_pkg::KIND_MERGE;
    end else begin
      cmd_o.kind = cef_pkg::KIND_POST;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cef_cmd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cef_cmd_queue - short command queue
// Small circular buffer of classified commands between the front end and
// the back end; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cef_cmd_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire cef_pkg::cmd_t        cmd_i,
  input  wire logic                 pop_i,
  output cef_pkg::cmd_t             head_o,
  output cef_pkg::cq_status_t       stat_o
);

  cef_pkg::cmd_t                     mem_q [cef_pkg::CQ_DEPTH];
  logic [cef_pkg::CQ_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [cef_pkg::CQ_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [cef_pkg::CQ_CNT_W-1:0]      cnt_q, cnt_d;
  logic                              do_push, do_pop;

  localparam logic [cef_pkg::CQ_PTR_W-1:0] LastPtr =
    cef_pkg::CQ_PTR_W'(cef_pkg::CQ_DEPTH - 1);
  localparam logic [cef_pkg::CQ_CNT_W-1:0] FullCnt =
    cef_pkg::CQ_CNT_W'(cef_pkg::CQ_DEPTH);

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i & ~stat_o.full;
  assign do_pop  = pop_i & ~stat_o.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cef_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cef_back - slot array and command execution
// Holds the shift-register slots. Each command passes through a look state,
// which compares keys and picks the oldest hit, then an apply state, which
// updates the slots and registers the result.
// ----------------------------------------------------------------------------
module cef_back #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire cef_pkg::cq_status_t             cq_stat_i,
  input  wire cef_pkg::cmd_t                   head_i,
  output logic                                 pop_o,
  output logic                                 res_valid_o,
  output logic [cef_pkg::STATUS_W-1:0]         status_o,
  output logic [cef_pkg::KEY_W-1:0]            out_key_o,
  output logic [cef_pkg::WORD_W-1:0]           out_word_o,
  output logic                                 pending_o
);

  // slot storage; valid marks an occupied slot
  logic [QUEUE_DEPTH-1:0]           valid_q, valid_d;
  logic [cef_pkg::KEY_W-1:0]        key_q  [QUEUE_DEPTH];
  logic [cef_pkg::KEY_W-1:0]        key_d  [QUEUE_DEPTH];
  logic [cef_pkg::WORD_W-1:0]       word_q [QUEUE_DEPTH];
  logic [cef_pkg::WORD_W-1:0]       word_d [QUEUE_DEPTH];

  // sequencer and look-stage registers
  cef_pkg::back_state_e             state_q, state_d;
  cef_pkg::cmd_t                    cmd_q;
  logic [QUEUE_DEPTH-1:0]           sel_q;
  logic                             hit_q;

  // look-stage logic
  logic [QUEUE_DEPTH-1:0]           match, vec, sel;
  logic                             higher;

  // apply-stage logic
  logic [cef_pkg::KEY_W-1:0]        rd_key;
  logic [cef_pkg::WORD_W-1:0]       rd_word;
  logic                             add_go;
  logic [cef_pkg::STATUS_W-1:0]     status_d;
  logic [cef_pkg::KEY_W-1:0]        okey_d;
  logic [cef_pkg::WORD_W-1:0]       oword_d;

  // result registers
  logic                             res_valid_q;
  logic [cef_pkg::STATUS_W-1:0]     status_q;
  logic [cef_pkg::KEY_W-1:0]        okey_q;
  logic [cef_pkg::WORD_W-1:0]       oword_q;
  logic                             pending_q;

  // look: key compare and oldest-hit select
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = valid_q[i] && (key_q[i] == head_i.key);
    end
    vec    = (head_i.kind == cef_pkg::KIND_MERGE) ? match : valid_q;
    higher = 1'b0;
    sel    = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      sel[i] = vec[i] & ~higher;
      higher = higher | vec[i];
    end
  end

  assign pop_o = (state_q == cef_pkg::BK_LOOK) && !cq_stat_i.empty;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      cef_pkg::BK_LOOK:  if (!cq_stat_i.empty) state_d = cef_pkg::BK_APPLY;
      cef_pkg::BK_APPLY: state_d = cef_pkg::BK_LOOK;
      default:           state_d = cef_pkg::BK_LOOK;
    endcase
  end

  // apply: read the selected slot
  always_comb begin
    rd_key  = '0;
    rd_word = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rd_key  = rd_key  | (key_q[i]  & {cef_pkg::KEY_W{sel_q[i]}});
      rd_word = rd_word | (word_q[i] & {cef_pkg::WORD_W{sel_q[i]}});
    end
  end

  // apply: slot update and result
  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    word_d   = word_q;
    add_go   = 1'b0;
    status_d = cef_pkg::ST_DROPPED;
    okey_d   = '0;
    oword_d  = '0;
    if (state_q == cef_pkg::BK_APPLY) begin
      case (cmd_q.kind)
        cef_pkg::KIND_TAKE: begin
          if (hit_q) begin
            valid_d  = valid_q & ~sel_q;
            status_d = cef_pkg::ST_TAKEN;
            okey_d   = rd_key;
            oword_d  = rd_word;
          end else begin
            status_d = cef_pkg::ST_EMPTY;
          end
        end
        cef_pkg::KIND_MERGE: begin
          if (hit_q) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (sel_q[i]) word_d[i] = cmd_q.word;
            end
            status_d = cef_pkg::ST_REPLACED;
          end else begin
            add_go = 1'b1;
          end
        end
        cef_pkg::KIND_POST: add_go = 1'b1;
        cef_pkg::KIND_DROP: status_d = cef_pkg::ST_DROPPED;
        default:            status_d = cef_pkg::ST_DROPPED;
      endcase
      // add at the new end unless the oldest slot is occupied
      if (add_go) begin
        if (valid_q[QUEUE_DEPTH-1]) begin
          status_d = cef_pkg::ST_DROPPED;
        end else begin
          for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
            key_d[i]  = key_q[i-1];
            word_d[i] = word_q[i-1];
          end
          key_d[0]  = cmd_q.key;
          word_d[0] = cmd_q.word;
          valid_d   = {valid_q[QUEUE_DEPTH-2:0], 1'b1};
          status_d  = cef_pkg::ST_ADDED;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cef_pkg::BK_LOOK;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      res_valid_q <= (state_q == cef_pkg::BK_APPLY);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    word_q <= word_d;
    if (pop_o) begin
      cmd_q <= head_i;
      sel_q <= sel;
      hit_q <= |vec;
    end
    if (state_q == cef_pkg::BK_APPLY) begin
      status_q  <= status_d;
      okey_q    <= okey_d;
      oword_q   <= oword_d;
      pending_q <= |valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = okey_q;
  assign out_word_o  = oword_q;
  assign pending_o   = pending_q;

endmodule
`default_nettype wire

// ===== sv/coalescing_event_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_event_fifo - coalescing event queue, top level
// Shift-register event queue with in-place replacement by key.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; it is classified
// and placed in a two-word command queue, so busy rises only when that queue
// is full. The execute unit handles one word at a time, in a look state (a
// key compare and oldest-hit select over all slots) and then an apply state
// (the slot update), and takes the next word only after the last is applied;
// results are registered and come out in order. Every word gives exactly one
// result, shown for one cycle; the receiver cannot stall it and must take it.
// ----------------------------------------------------------------------------
module coalescing_event_fifo #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            op_i,
  input  wire logic [cef_pkg::KEY_W-1:0]       event_key_i,
  input  wire logic [cef_pkg::WORD_W-1:0]      event_word_i,
  input  wire logic                            coalesce_i,
  output logic                                 result_valid_o,
  output logic [cef_pkg::STATUS_W-1:0]         status_o,
  output logic [cef_pkg::KEY_W-1:0]            out_key_o,
  output logic [cef_pkg::WORD_W-1:0]           out_word_o,
  output logic                                 pending_o
);

  cef_pkg::cq_status_t  cq_stat;
  cef_pkg::cmd_t        push_cmd, head_cmd;
  logic                 push, pop;

  // intake and classification
  cef_front u_front (
    .start        (start),
    .op_i         (op_i),
    .event_key_i  (event_key_i),
    .event_word_i (event_word_i),
    .coalesce_i   (coalesce_i),
    .cq_stat_i    (cq_stat),
    .busy         (busy),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // decoupling queue
  cef_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (cq_stat)
  );

  // slot array and execution
  cef_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cq_stat_i   (cq_stat),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .status_o    (status_o),
    .out_key_o   (out_key_o),
    .out_word_o  (out_word_o),
    .pending_o   (pending_o)
  );

endmodule
`default_nettype wire

// ===== sv/cef_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cef_checker - port-level checks
// Watches the result ports of the event queue and is bound to the top level.
// ----------------------------------------------------------------------------
module cef_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        result_valid_o,
  input wire logic [cef_pkg::STATUS_W-1:0] status_o,
  input wire logic [cef_pkg::KEY_W-1:0]   out_key_o,
  input wire logic [cef_pkg::WORD_W-1:0]  out_word_o,
  input wire logic                        pending_o
);

  // anything added, replaced or just taken leaves the queue non-empty
  // unless the take emptied it; adds and replaces always leave an entry
  a_pending_after_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == cef_pkg::ST_ADDED ||
                       status_o == cef_pkg::ST_REPLACED) |-> pending_o)
    else $error("add or replace reported with no pending entry");

  // an empty take means nothing is left
  a_empty_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == cef_pkg::ST_EMPTY |-> !pending_o)
    else $error("empty take reported with pending entries");

  // only a successful take carries data
  a_no_data_unless_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != cef_pkg::ST_TAKEN |->
      out_key_o == '0 && out_word_o == '0)
    else $error("data shown on a result that is not a take");

  // a taken entry always has a nonzero key
  a_taken_key_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == cef_pkg::ST_TAKEN |-> out_key_o != '0)
    else $error("taken entry has key zero");

  // each word passes through a look state before its apply state, so strobes never come back to back
  a_strobe_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobes in consecutive cycles");

endmodule

bind coalescing_event_fifo cef_checker u_cef_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .out_key_o      (out_key_o),
  .out_word_o     (out_word_o),
  .pending_o      (pending_o)
);
`default_nettype wire
